// ===== hdl/ipv4p_pkg.sv =====
`timescale 1ns / 1ps

package ipv4p_pkg;

   // One character of the address text.
   typedef struct packed {
      logic [7:0] ch;
      logic       first;
   } req_type;

   // One parsed address.
   typedef struct packed {
      logic [31:0] address;
      logic        status;
   } rsp_type;

   localparam int unsigned MAX_CHARS_DEFAULT = 16;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   // Longest part in characters, and the index of the last part.
   localparam logic [1:0] PART_CHARS = 2'd3;
   localparam logic [1:0] LAST_PART  = 2'd3;

   localparam logic STATUS_ERROR = 1'b0;
   localparam logic STATUS_OK    = 1'b1;

endpackage

// ===== hdl/ipv4_dotted_text_parser.sv =====
`timescale 1ns / 1ps

// Streaming parser for dotted-decimal IPv4 address text.
//
// The req_ channel carries one character per word, with a flag that marks the
// first character of a new string; that flag restarts the parser. Each part
// (up to three characters) is converted atoi-style: an optional leading minus,
// then value*10 + (ch - '0') per character, kept modulo 256. At most one rsp_
// word is produced per string: the 32-bit address with status 1 once the
// fourth part ends at a dot or terminator, or address 0 with status 0 on an
// empty part, a fourth character in a part, an early terminator or reaching
// MAX_CHARS characters. Characters after the result are ignored until the next
// first flag.
//
// One character is accepted every cycle while req_stall is low. The running
// parse state is updated at the accepting edge, and a result sits in the
// output register from the next cycle on. The output register holds its word
// while the receiver stalls; req_stall rises only while that register is full
// and stalled. After reset the block ignores characters until one arrives
// flagged as first.
module ipv4_dotted_text_parser #(
   parameter int unsigned MAX_CHARS = ipv4p_pkg::MAX_CHARS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ipv4p_pkg::req_type req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ipv4p_pkg::rsp_type rsp_word
);

   // The character counter only has to reach MAX_CHARS itself.
   localparam int unsigned CW = $clog2(MAX_CHARS + 1);

   logic [CW-1:0]      char_index_ff, char_index_in;
   logic [1:0]         part_length_ff, part_length_in;
   logic [1:0]         part_number_ff, part_number_in;
   logic [7:0]         part_value_ff, part_value_in;
   logic               part_negative_ff, part_negative_in;
   logic [31:0]        address_acc_ff, address_acc_in;
   logic               finished_ff, finished_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ipv4p_pkg::rsp_type rsp_ff, rsp_in;

   logic               req_accept;
   logic               emit_c;

   // A new word can always be taken unless a finished result is held back.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      logic [CW-1:0] idx;
      logic [1:0]    len;
      logic [1:0]    pn;
      logic [7:0]    pv;
      logic          neg;
      logic [31:0]   acc;
      logic          fin;
      logic [7:0]    val;
      logic [31:0]   acc_new;
      logic [7:0]    ch;

      // A first flag clears the parse before its own character is handled.
      ch  = req_word.ch;
      idx = req_word.first ? '0    : char_index_ff;
      len = req_word.first ? 2'd0  : part_length_ff;
      pn  = req_word.first ? 2'd0  : part_number_ff;
      pv  = req_word.first ? 8'd0  : part_value_ff;
      neg = req_word.first ? 1'b0  : part_negative_ff;
      acc = req_word.first ? 32'd0 : address_acc_ff;
      fin = req_word.first ? 1'b0  : finished_ff;

      val     = neg ? 8'(8'd0 - pv) : pv;
      acc_new = acc | (32'(val) << {~pn, 3'b000});

      char_index_in    = char_index_ff;
      part_length_in   = part_length_ff;
      part_number_in   = part_number_ff;
      part_value_in    = part_value_ff;
      part_negative_in = part_negative_ff;
      address_acc_in   = address_acc_ff;
      finished_in      = finished_ff;
      emit_c           = 1'b0;
      rsp_in.address   = 32'd0;
      rsp_in.status    = ipv4p_pkg::STATUS_ERROR;

      if (req_accept) begin
         char_index_in    = idx;
         part_length_in   = len;
         part_number_in   = pn;
         part_value_in    = pv;
         part_negative_in = neg;
         address_acc_in   = acc;
         finished_in      = fin;
         if (!fin) begin
            if (idx >= CW'(MAX_CHARS)) begin
               emit_c = 1'b1;
            end else if (ch == ipv4p_pkg::CHAR_DOT || ch == ipv4p_pkg::CHAR_NUL) begin
               if (len == 2'd0) begin
                  emit_c = 1'b1;
               end else if (pn == ipv4p_pkg::LAST_PART) begin
                  emit_c         = 1'b1;
                  rsp_in.address = acc_new;
                  rsp_in.status  = ipv4p_pkg::STATUS_OK;
               end else if (ch == ipv4p_pkg::CHAR_NUL) begin
                  // The string ended before its fourth part.
                  emit_c = 1'b1;
               end else begin
                  address_acc_in   = acc_new;
                  part_number_in   = pn + 2'd1;
                  part_length_in   = 2'd0;
                  part_value_in    = 8'd0;
                  part_negative_in = 1'b0;
                  char_index_in    = idx + CW'(1);
               end
            end else if (len == ipv4p_pkg::PART_CHARS) begin
               emit_c = 1'b1;
            end else begin
               // Only a minus that opens its part is a sign; any other
               // character is folded in as a digit, whatever it is.
               if (len == 2'd0 && ch == ipv4p_pkg::CHAR_MINUS) begin
                  part_negative_in = 1'b1;
               end else begin
                  part_value_in = {pv[4:0], 3'b000} + {pv[6:0], 1'b0} + ch
                                  - ipv4p_pkg::CHAR_ZERO;
               end
               part_length_in = len + 2'd1;
               char_index_in  = idx + CW'(1);
            end
            if (emit_c) begin
               finished_in = 1'b1;
            end
         end
      end

      rsp_valid_in = emit_c | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_index_ff    <= '0;
         part_length_ff   <= 2'd0;
         part_number_ff   <= 2'd0;
         part_value_ff    <= 8'd0;
         part_negative_ff <= 1'b0;
         address_acc_ff   <= 32'd0;
         finished_ff      <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         char_index_ff    <= char_index_in;
         part_length_ff   <= part_length_in;
         part_number_ff   <= part_number_in;
         part_value_ff    <= part_value_in;
         part_negative_ff <= part_negative_in;
         address_acc_ff   <= address_acc_in;
         finished_ff      <= finished_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // The result word is loaded only when a new result is made; the accept
   // condition already guarantees the register is free or being drained.
   always_ff @(posedge clock) begin
      if (emit_c) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTHESIS
   // Every result closes the string: nothing more until the next first flag.
   a_finish_after_result : assert property (@(posedge clock) disable iff (reset)
      emit_c |=> finished_ff)
      else $error("parser not finished after giving a result");

   // A finished string without a new first flag never yields a result.
   a_quiet_when_finished : assert property (@(posedge clock) disable iff (reset)
      req_accept && finished_ff && !req_word.first |-> !emit_c)
      else $error("result produced for an already finished string");

   // An error result always carries a zero address.
   a_error_zero_address : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ipv4p_pkg::STATUS_ERROR
         |-> rsp_ff.address == 32'd0)
      else $error("error result with non-zero address");

   // The character counter never runs past the limit.
   a_index_bounded : assert property (@(posedge clock) disable iff (reset)
      char_index_ff <= CW'(MAX_CHARS))
      else $error("character counter beyond limit");
`endif

endmodule

// ===== tb/ipv4_dotted_text_parser_tb.sv =====
`timescale 1ns / 1ps

module ipv4_dotted_text_parser_tb;

   localparam int CLK_PERIOD = 20;

   // The block is built with its default character limit. A text of four parts
   // of at most three characters each always ends before that limit.
   localparam int unsigned CHAR_LIMIT = ipv4p_pkg::MAX_CHARS_DEFAULT;

   // Number of characters sent in the random part, ignored ones included.
   localparam int RANDOM_CHARS = 1350;

   // Kinds of address text that the random part builds.
   typedef enum int {
      TEXT_CLEAN,
      TEXT_EMPTY_PART,
      TEXT_LONG_PART,
      TEXT_EARLY_END,
      TEXT_CUT,
      TEXT_NOISE
   } text_kind_type;

   // Tracks the parse state of the text that is being sent and keeps the
   // addresses that the block is due to produce, oldest first.
   class address_scoreboard;
      ipv4p_pkg::rsp_type expected_q[$];
      int         errors;
      bit [6:0]   pos;
      bit [1:0]   part_len;
      bit [2:0]   parts_done;
      bit [7:0]   part_acc;
      bit         part_neg;
      bit [31:0]  addr_acc;
      bit         done;

      function new();
         errors = 0;
         restart_text();
         done = 1'b1;
      endfunction

      function void restart_text();
         pos        = '0;
         part_len   = '0;
         parts_done = '0;
         part_acc   = '0;
         part_neg   = 1'b0;
         addr_acc   = '0;
      endfunction

      function void emit_address(bit [31:0] addr, logic status);
         ipv4p_pkg::rsp_type r;
         r.address = addr;
         r.status  = status;
         expected_q.push_back(r);
         done = 1'b1;
      endfunction

      // Notes one accepted character. Returns 1 if the parser acts upon it.
      function bit note_char(ipv4p_pkg::req_type w);
         bit [7:0] val;
         int       shift;
         if (w.first) begin
            restart_text();
            done = 1'b0;
         end
         if (done)
            return 1'b0;
         if (pos >= CHAR_LIMIT) begin
            emit_address('0, ipv4p_pkg::STATUS_ERROR);
            return 1'b1;
         end
         if (w.ch == ipv4p_pkg::CHAR_DOT || w.ch == ipv4p_pkg::CHAR_NUL) begin
            if (part_len == 0) begin
               emit_address('0, ipv4p_pkg::STATUS_ERROR);
               return 1'b1;
            end
            val = part_neg ? -part_acc : part_acc;
            shift = 8 * (3 - int'(parts_done));
            addr_acc |= {24'd0, val} << shift;
            parts_done++;
            if (parts_done == 3'd4)
               emit_address(addr_acc, ipv4p_pkg::STATUS_OK);
            else if (w.ch == ipv4p_pkg::CHAR_NUL)
               emit_address('0, ipv4p_pkg::STATUS_ERROR);
            else begin
               part_len = '0;
               part_acc = '0;
               part_neg = 1'b0;
               pos++;
            end
            return 1'b1;
         end
         if (part_len == ipv4p_pkg::PART_CHARS) begin
            emit_address('0, ipv4p_pkg::STATUS_ERROR);
            return 1'b1;
         end
         // Only a minus at the head of a part is a sign; anywhere else it is
         // folded in like any other character.
         if (part_len == 0 && w.ch == ipv4p_pkg::CHAR_MINUS)
            part_neg = 1'b1;
         else
            part_acc = part_acc * 8'd10 + w.ch - ipv4p_pkg::CHAR_ZERO;
         part_len++;
         pos++;
         return 1'b1;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void check_address(ipv4p_pkg::rsp_type got);
         ipv4p_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word, address %h status %b", $time,
                     got.address, got.status);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.address !== want.address) begin
            $display("%0t: address expected %h, got %h", $time, want.address,
                     got.address);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %b, got %b", $time, want.status,
                     got.status);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   ipv4p_pkg::req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   ipv4p_pkg::rsp_type rsp_word;

   address_scoreboard sb;

   // Text being sent, one byte per character.
   bit [7:0] text[$];

   int       chars_sent = 0;
   int       burst_left = 0;
   bit [15:0] rx_cycle = '0;

   ipv4_dotted_text_parser #(
      .MAX_CHARS(CHAR_LIMIT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Offers one character and waits for the edge at which it is taken. After
   // that, the sender either carries straight on with its burst or drops valid
   // for a few cycles. Now and then a burst is long enough to give a stretch
   // with no idling at all.
   task automatic put_char(bit [7:0] c, bit first);
      ipv4p_pkg::req_type w;
      w.ch    = c;
      w.first = first;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      void'(sb.note_char(w));
      chars_sent++;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   // Sends the text held in the queue, with the first flag on its first byte.
   task automatic send_text();
      foreach (text[i])
         put_char(text[i], i == 0);
   endtask

   task automatic load_text(string s, bit with_nul);
      text.delete();
      for (int i = 0; i < s.len(); i++)
         text.push_back(s[i]);
      if (with_nul)
         text.push_back(ipv4p_pkg::CHAR_NUL);
   endtask

   // A character of a part: mostly digits, with a sign now and then, a minus
   // in the middle of a part, and odd bytes that are neither a dot nor the
   // terminator.
   function automatic bit [7:0] part_char(int at);
      int       r;
      bit [7:0] b;
      r = $urandom_range(0, 99);
      if (at == 0 && r < 12)
         return ipv4p_pkg::CHAR_MINUS;
      if (r < 85)
         return ipv4p_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
      if (r < 90)
         return ipv4p_pkg::CHAR_MINUS;
      do b = 8'($urandom_range(1, 255)); while (b == ipv4p_pkg::CHAR_DOT);
      return b;
   endfunction

   function automatic bit [7:0] noise_char();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3)
         return ipv4p_pkg::CHAR_DOT;
      if (r < 6)
         return ipv4p_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
      if (r == 6)
         return ipv4p_pkg::CHAR_NUL;
      if (r == 7)
         return ipv4p_pkg::CHAR_MINUS;
      return 8'($urandom_range(0, 255));
   endfunction

   // Builds one random text. Most are four well-formed parts with random
   // content; the rest have one part spoilt, end early, are cut short so that
   // the next text abandons them, or are plain noise. Bytes after the end are
   // ignored by the parser and are there to prove it.
   task automatic make_text();
      text_kind_type kind;
      int         pick;
      int         bad;
      int         len;
      int         cut;
      text.delete();
      pick = $urandom_range(0, 99);
      if (pick < 60)
         kind = TEXT_CLEAN;
      else if (pick < 67)
         kind = TEXT_EMPTY_PART;
      else if (pick < 74)
         kind = TEXT_LONG_PART;
      else if (pick < 81)
         kind = TEXT_EARLY_END;
      else if (pick < 90)
         kind = TEXT_CUT;
      else
         kind = TEXT_NOISE;
      if (kind == TEXT_NOISE) begin
         repeat ($urandom_range(1, 18)) text.push_back(noise_char());
         return;
      end
      bad = (kind == TEXT_EARLY_END) ? $urandom_range(0, 2) : $urandom_range(0, 3);
      for (int p = 0; p < 4; p++) begin
         if (p > 0)
            text.push_back(ipv4p_pkg::CHAR_DOT);
         len = $urandom_range(1, 3);
         if (p == bad && kind == TEXT_EMPTY_PART)
            len = 0;
         if (p == bad && kind == TEXT_LONG_PART)
            len = 4;
         for (int i = 0; i < len; i++)
            text.push_back(part_char(i));
         if (p == bad && kind == TEXT_EARLY_END)
            break;
      end
      if (kind == TEXT_EARLY_END)
         text.push_back(ipv4p_pkg::CHAR_NUL);
      else
         text.push_back($urandom_range(0, 1) ? ipv4p_pkg::CHAR_NUL : ipv4p_pkg::CHAR_DOT);
      repeat ($urandom_range(0, 2)) text.push_back(noise_char());
      if (kind == TEXT_CUT) begin
         cut = $urandom_range(1, text.size() - 1);
         while (text.size() > cut)
            void'(text.pop_back());
      end
   endtask

   // The receiver checks every word it takes and then picks its next stall
   // from a pattern that rx_cycle[9:8] selects: no stall at all, coin
   // flips, a fixed heavy duty cycle, or mostly stalled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_address(rsp_word);
         rx_cycle <= rx_cycle + 16'd1;
         case (rx_cycle[9:8])
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= 1'($urandom_range(0, 1));
            2'd2: rsp_stall <= (rx_cycle[2:0] < 3'd5);
            default: rsp_stall <= ($urandom_range(0, 9) < 8);
         endcase
      end
   end

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A byte before any first flag must be ignored.
      put_char(8'hFF, 1'b0);
      // Lone minus, minus inside a part, a full-width part, a negative part,
      // and a fourth part that ends at a dot. The byte after it is ignored.
      load_text("-.1-.255.-5.", 1'b0);
      send_text();
      put_char(8'hFF, 1'b0);
      // Empty part.
      load_text("1..", 1'b0);
      send_text();
      // Fourth character in a part.
      load_text("1234", 1'b0);
      send_text();
      // Terminator after the first part.
      load_text("7", 1'b1);
      send_text();

      chars_sent = 0;
      while (chars_sent < RANDOM_CHARS) begin
         make_text();
         send_text();
      end
      req_valid <= 1'b0;

      // Let the last words drain, then give the block a few more cycles to
      // show any word that it should not produce.
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (sb.errors == 0)
         $display("PASS ipv4_dotted_text_parser");
      else
         $display("FAIL ipv4_dotted_text_parser");
      $finish;
   end

   // Guards against a hung handshake: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("FAIL ipv4_dotted_text_parser");
      $finish;
   end

endmodule
